// ----- rtl/sst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

   // Default number of entries held in the table.
   localparam int CAPACITY_DEFAULT = 16;

   // Field widths fixed by the interface.
   localparam int KIND_W   = 2;
   localparam int SCORE_W  = 32;
   localparam int NAME_W   = 64;
   localparam int STATUS_W = 3;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_DUMPED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

   // One stored entry: score and packed name tag.
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [NAME_W-1:0]         name_tag;
   } entry_type;

   // Commands broadcast along the row of cells.
   typedef struct packed {
      logic insert;
      logic rotate;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/sst_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sst_cell
   import sst_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          occupied,
   input  wire logic          is_tail,
   input  wire logic          prev_take,
   input  wire entry_type     new_entry,
   input  wire entry_type     left_entry,
   input  wire entry_type     right_entry,
   input  wire entry_type     head_entry,
   output logic               take,
   output entry_type          entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // The new entry belongs at or before this slot when the slot is free or
   // holds a score no greater than the new one, so equal scores move down.
   assign take  = !occupied || ($signed(new_entry.score) >= $signed(entry_ff.score));
   assign entry = entry_ff;

   // On insert the first taking cell loads the new entry and every later one
   // takes its left neighbour. During a dump the occupied cells rotate left,
   // with the tail refilled from the head.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && take) begin
         entry_in = prev_take ? left_entry : new_entry;
      end else if (ctrl.rotate) begin
         entry_in = is_tail ? head_entry : right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ----- rtl/sorted_score_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sorted score table: holds up to CAPACITY entries in descending score order,
// a new entry placed ahead of stored entries of equal score. Insert and clear
// each give their single response on the strobe in the following cycle;
// back-to-back inserts run at one per cycle. A dump keeps busy high while
// the row of cells rotates its contents past the head, one entry per cycle,
// and each response is registered from the head entry, the final one marked
// by rsp_last. An empty dump gives one response in the cycle after the
// request. The receiver cannot stall: every response is a transfer in the
// single cycle its strobe is high. No clearing pass follows reset.
module sorted_score_table
   import sst_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic signed [SCORE_W-1:0] req_score,
   input  wire logic [NAME_W-1:0]         req_name_tag,
   output logic                           rsp_strobe,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic signed [SCORE_W-1:0]      rsp_score_res,
   output logic [NAME_W-1:0]              rsp_name_tag_res,
   output logic                           rsp_last
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                dumping_ff, dumping_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                strobe_ff, strobe_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   entry_type           res_ff, res_in;
   logic                last_ff, last_in;

   logic          accept;
   logic          full;
   logic          dump_last;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     dropped;
   entry_type     cell_q [CAPACITY];
   logic          cell_take [CAPACITY];

   assign busy      = dumping_ff;
   assign accept    = start && !dumping_ff;
   assign full      = (count_ff == COUNT_W'(CAPACITY));
   assign dump_last = ((COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff);

   assign new_entry.score    = req_score;
   assign new_entry.name_tag = req_name_tag;

   assign ctrl.insert = accept && (req_kind == KIND_INSERT);
   assign ctrl.rotate = dumping_ff;

   // Row of cells, each handing its entry to both neighbours.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sst_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (COUNT_W'(i) < count_ff),
         .is_tail     (COUNT_W'(i + 1) == count_ff),
         .prev_take   ((i == 0) ? 1'b0 : cell_take[(i == 0) ? 0 : i - 1]),
         .new_entry   (new_entry),
         .left_entry  (cell_q[(i == 0) ? 0 : i - 1]),
         .right_entry (cell_q[(i == CAPACITY - 1) ? 0 : i + 1]),
         .head_entry  (cell_q[0]),
         .take        (cell_take[i]),
         .entry       (cell_q[i])
      );
   end

   // A full table loses its last entry if that one shifts, else the new entry.
   assign dropped = cell_take[CAPACITY-1] ? cell_q[CAPACITY-1] : new_entry;

   // Request decoding, dump sequencing and the response register.
   always_comb begin
      count_in   = count_ff;
      dumping_in = dumping_ff;
      idx_in     = idx_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      res_in     = '0;
      last_in    = 1'b1;
      if (dumping_ff) begin
         strobe_in = 1'b1;
         status_in = ST_DUMPED;
         res_in    = cell_q[0];
         last_in   = dump_last;
         idx_in    = IDX_W'(idx_ff + 1'b1);
         if (dump_last) begin
            dumping_in = 1'b0;
         end
      end else if (accept) begin
         case (req_kind)
            KIND_INSERT: begin
               strobe_in = 1'b1;
               if (full) begin
                  status_in = ST_DROPPED;
                  res_in    = dropped;
               end else begin
                  status_in = ST_INSERTED;
                  count_in  = COUNT_W'(count_ff + 1'b1);
               end
            end
            KIND_DUMP: begin
               if (count_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = ST_EMPTY;
               end else begin
                  dumping_in = 1'b1;
                  idx_in     = '0;
               end
            end
            KIND_CLEAR: begin
               strobe_in = 1'b1;
               status_in = ST_CLEARED;
               count_in  = '0;
            end
            default: begin
               strobe_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dumping_ff <= 1'b0;
         idx_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dumping_ff <= dumping_in;
         idx_ff     <= idx_in;
         strobe_ff  <= strobe_in;
      end
      status_ff <= status_in;
      res_ff    <= res_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_score_res    = res_ff.score;
   assign rsp_name_tag_res = res_ff.name_tag;
   assign rsp_last         = last_ff;

   // A dump only runs over a non-empty table.
   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      dumping_ff |-> (count_ff != '0))
      else $error("dump running over an empty table");

   // A response not marked last is always followed by another response.
   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !last_ff) |=> strobe_ff)
      else $error("dump stream broken before its last transfer");

   // An accepted clear empties the table and reports it in the next cycle.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_CLEAR)) |=>
         (strobe_ff && (status_ff == ST_CLEARED) && (count_ff == '0)))
      else $error("clear not reported or table not emptied");

endmodule

`default_nettype wire
